@@ design/wfsa_pkg.sv @@
// Package: shared types and constants for the word frame sum/add-check encoder.
`default_nettype none
package wfsa_pkg;

  localparam int WORD_W      = 16;
  localparam int COUNT_W     = 5;
  localparam int BYTE_W      = 8;
  localparam int MAX_WORDS_DEF = 16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

  localparam logic [BYTE_W-1:0] HDR_SYNC = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_ADDR = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_FUNC = 8'hF1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // one classified word waiting for the serializer
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              opens;
    logic              closes;
    logic [BYTE_W-1:0] len;
  } ent_t;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_ADDR,
    PH_FUNC,
    PH_LEN,
    PH_LO,
    PH_HI,
    PH_SUM,
    PH_ADD
  } phase_t;

endpackage
`default_nettype wire

@@ design/wfsa_front.sv @@
// Front end: word count register, frame position tracking and word classification.
`default_nettype none
module wfsa_front #(
  parameter int MAX_WORDS = wfsa_pkg::MAX_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [wfsa_pkg::COUNT_W-1:0] cfg_word_count,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [wfsa_pkg::WORD_W-1:0] in_word_value,
  input  wire logic                        q_full,
  output logic                             q_push,
  output wfsa_pkg::ent_t                   q_ent
);
  import wfsa_pkg::*;

  logic [COUNT_W-1:0] word_count_r, word_count_nxt;
  logic [COUNT_W-1:0] word_index_r, word_index_nxt;
  logic               closing;

  always_comb begin
    word_count_nxt = word_count_r;
    if (cfg_we) begin
      if (cfg_word_count == '0) begin
        word_count_nxt = COUNT_W'(1);
      end else if (int'(cfg_word_count) > MAX_WORDS) begin
        word_count_nxt = COUNT_W'(MAX_WORDS);
      end else begin
        word_count_nxt = cfg_word_count;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign closing  = ({1'b0, word_index_r} + (COUNT_W+1)'(1)) >= {1'b0, word_count_r};

  always_comb begin
    q_ent.word   = in_word_value;
    q_ent.opens  = (word_index_r == '0);
    q_ent.closes = closing;
    q_ent.len    = {{(BYTE_W-COUNT_W-1){1'b0}}, word_count_r, 1'b0};
  end

  always_comb begin
    word_index_nxt = word_index_r;
    if (q_push) begin
      word_index_nxt = closing ? '0 : word_index_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= COUNT_RESET;
      word_index_r <= '0;
    end else begin
      word_count_r <= word_count_nxt;
      word_index_r <= word_index_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/wfsa_queue.sv @@
// Short FIFO of classified words between front end and serializer.
`default_nettype none
module wfsa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wfsa_pkg::ent_t push_ent,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output wfsa_pkg::ent_t      head_ent
);
  import wfsa_pkg::*;

  ent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (int'(p) == QDEPTH - 1) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (int'(count_r) == QDEPTH);
  assign head_valid = (count_r != '0);
  assign head_ent   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/wfsa_back.sv @@
// Serializer: emits header, payload and check bytes and keeps the sum and add checks.
`default_nettype none
module wfsa_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire wfsa_pkg::ent_t              head_ent,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [wfsa_pkg::BYTE_W-1:0]      out_frame_byte,
  output logic                             out_end_of_item,
  output logic                             out_end_of_frame
);
  import wfsa_pkg::*;

  phase_t            phase_r, phase_nxt, eff;
  logic              start_r, start_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt, add_r, add_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_eoi_r, out_eoi_nxt;
  logic              out_eof_r, out_eof_nxt;

  logic              adv, last, summed;
  logic [BYTE_W-1:0] cur_byte, base_sum, base_add;

  // at the start of a word the phase comes from the queue head
  assign eff = start_r ? (head_ent.opens ? PH_SYNC : PH_LO) : phase_r;
  assign adv = head_valid && (!out_valid_r || out_ready);
  assign pop = adv && last;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    if (adv) begin
      if (last) begin
        start_nxt = 1'b1;
      end else begin
        start_nxt = 1'b0;
        case (eff)
          PH_SYNC: phase_nxt = PH_ADDR;
          PH_ADDR: phase_nxt = PH_FUNC;
          PH_FUNC: phase_nxt = PH_LEN;
          PH_LEN:  phase_nxt = PH_LO;
          PH_LO:   phase_nxt = PH_HI;
          PH_HI:   phase_nxt = PH_SUM;
          PH_SUM:  phase_nxt = PH_ADD;
          default: phase_nxt = PH_SYNC;
        endcase
      end
    end
  end

  // outputs of the current phase
  always_comb begin
    cur_byte = sum_r;
    summed   = 1'b1;
    last     = 1'b0;
    case (eff)
      PH_SYNC: cur_byte = HDR_SYNC;
      PH_ADDR: cur_byte = HDR_ADDR;
      PH_FUNC: cur_byte = HDR_FUNC;
      PH_LEN:  cur_byte = head_ent.len;
      PH_LO:   cur_byte = head_ent.word[7:0];
      PH_HI: begin
        cur_byte = head_ent.word[15:8];
        last     = !head_ent.closes;
      end
      PH_SUM: begin
        cur_byte = sum_r;
        summed   = 1'b0;
      end
      default: begin
        cur_byte = add_r;
        summed   = 1'b0;
        last     = 1'b1;
      end
    endcase
  end

  always_comb begin
    base_sum = (eff == PH_SYNC) ? '0 : sum_r;
    base_add = (eff == PH_SYNC) ? '0 : add_r;
    sum_nxt  = sum_r;
    add_nxt  = add_r;
    if (adv && summed) begin
      sum_nxt = base_sum + cur_byte;
      add_nxt = base_add + base_sum + cur_byte;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_eoi_nxt   = out_eoi_r;
    out_eof_nxt   = out_eof_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_eoi_nxt   = last;
      out_eof_nxt   = (eff == PH_ADD);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_end_of_item  = out_eoi_r;
  assign out_end_of_frame = out_eof_r;

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    add_r      <= add_nxt;
    out_byte_r <= out_byte_nxt;
    out_eoi_r  <= out_eoi_nxt;
    out_eof_r  <= out_eof_nxt;
    phase_r    <= phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/word_frame_sum_add_check_encoder_core.sv @@
// An accepted word is held in the word queue, then its first byte in the output register.
// Throughput: one byte per cycle from the serializer while a word is queued and out_ready is
// high; 2 bytes per word mid-frame, plus 4 header bytes on a frame's first word and 2 check
// bytes on its last. A 2-entry word queue decouples input acceptance from byte output.
// Reset (rst_n, synchronous): word count 10, frame position 0, queue and output register empty.
`default_nettype none
module word_frame_sum_add_check_encoder_core #(
  parameter int MAX_WORDS = wfsa_pkg::MAX_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [wfsa_pkg::COUNT_W-1:0] cfg_word_count,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [wfsa_pkg::WORD_W-1:0]  in_word_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [wfsa_pkg::BYTE_W-1:0]       out_frame_byte,
  output logic                              out_end_of_item,
  output logic                              out_end_of_frame
);
  import wfsa_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  ent_t q_ent, q_head;

  wfsa_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_word_count (cfg_word_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word_value  (in_word_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_ent          (q_ent)
  );

  wfsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ent   (q_ent),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_ent   (q_head)
  );

  wfsa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_ent         (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_end_of_item  (out_end_of_item),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
`default_nettype wire
